// ===== rtl/sete_pkg.sv =====
// sete_pkg: shared constants for the Sobel edge threshold block.
// Field widths, register indexes and register reset values.
// No dependencies.
package sete_pkg;

  localparam int MAX_WIDTH_DEF = 2048;  // default line store depth

  localparam int PIX_W     = 8;   // grey pixel / edge value width
  localparam int ROW_W     = 12;  // row counter and out_row width
  localparam int CFG_W     = 12;  // config register width
  localparam int CFG_IDX_W = 2;   // config register index width

  localparam logic [PIX_W-1:0] EDGE_ON = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_t;

  localparam logic [CFG_W-1:0] THRESHOLD_RST    = 12'd300;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

endpackage

// ===== rtl/sete_ram.sv =====
// sete_ram: generic single-clock RAM, one write port, one read port.
// Read data is registered and holds while rd_en is low; read-first on collision.
// No dependencies.
module sete_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sobel_edge_threshold.sv =====
// sobel_edge_threshold: 3x3 Sobel edge detector with threshold on a raster pixel stream.
// Words pass stages 1 to 3 and the output register. Throughput: 1 pixel/cycle unless out stalls.
// Rate is set by the line store RAMs: one read and one write per RAM per cycle.
// Reset: counters and config return to defaults, then a clearing pass over every address
// zeroes both line stores; in_tready stays low during it, config writes are taken.
// Depends on sete_pkg and sete_ram.
module sobel_edge_threshold #(
  parameter int MAX_WIDTH = sete_pkg::MAX_WIDTH_DEF,
  // derived, do not override
  parameter int COL_W  = $clog2(MAX_WIDTH),
  parameter int OUT_DW = ((sete_pkg::PIX_W + sete_pkg::ROW_W + COL_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input: tdata = pixel[7:0]; tuser = frame_start[0]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sete_pkg::PIX_W-1:0]      in_tdata,
  input  logic [0:0]                      in_tuser,
  // edge result: tdata = edge_value[7:0], out_row[19:8], out_col[20 +: COL_W], zero pad
  // tlast = end_of_frame
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DW-1:0]               out_tdata,
  output logic                            out_tlast,
  // config write: index 0 threshold, 1 frame_width, 2 frame_height
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sete_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sete_pkg::CFG_W-1:0]      cfg_data
);

  import sete_pkg::*;

  localparam int AW    = COL_W;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMPW  = ((WW > CFG_W) ? WW : CFG_W) + 1;  // room for count + 1
  localparam int PAD_W = OUT_DW - PIX_W - ROW_W - COL_W;

  // ---------------------------------------------------------------------------
  // Config registers. Always ready; write only while the stream is idle (not enforced).
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] threshold_r, frame_width_r, frame_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_r    <= cfg_data;
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The whole pipe advances together on 'adv'; a skid register
  // behind the output register lets one more result land while out is stalled.
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_valid_r;
  logic clear_r;
  logic [AW-1:0] clr_cnt_r;
  logic in_acc;

  assign adv       = !skid_valid_r;
  assign in_tready = adv && !clear_r;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Stage 0: raster counters, interior test, line store read issue.
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [CMPW-1:0]  w_eff, h_ext, r_inc, c_inc, r_ext, c_ext;
  logic             interior0, eof0, col_wrap, row_wrap;

  always_comb begin
    r0 = in_tuser[0] ? '0 : row_cnt_r;
    c0 = in_tuser[0] ? '0 : col_cnt_r;
    // width saturates at the line store depth
    w_eff = (CMPW'(frame_width_r) > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH)
                                                       : CMPW'(frame_width_r);
    h_ext = CMPW'(frame_height_r);
    r_ext = CMPW'(r0);
    c_ext = CMPW'(c0);
    r_inc = r_ext + CMPW'(1);
    c_inc = c_ext + CMPW'(1);
    col_wrap  = c_inc >= w_eff;
    row_wrap  = r_inc >= h_ext;
    interior0 = (r_ext >= CMPW'(2)) && (c_ext >= CMPW'(2)) &&
                (r_ext < h_ext) && (c_ext < w_eff);
    eof0      = (r_inc == h_ext) && (c_inc == w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_cnt_r <= '0;
        row_cnt_r <= row_wrap ? '0 : r0 + ROW_W'(1);
      end else begin
        col_cnt_r <= c0 + COL_W'(1);
        row_cnt_r <= r0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores: upper holds line r-2, middle line r-1, indexed by column.
  // Read at accept, written back from stage 1 when the pipe advances.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_int_r, s1_eof_r, s1_fwd_r;
  logic [PIX_W-1:0] fwd_upper_r, fwd_mid_r;
  logic [PIX_W-1:0] rd_upper, rd_mid, top1, mid1;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PIX_W-1:0] upper_wdata, mid_wdata;

  // same column as the word in stage 1: its write lands in the read cycle,
  // so the RAM returns the old value and the written one is forwarded
  assign top1 = s1_fwd_r ? fwd_upper_r : rd_upper;
  assign mid1 = s1_fwd_r ? fwd_mid_r   : rd_mid;

  always_comb begin
    if (clear_r) begin
      ram_we      = 1'b1;
      ram_waddr   = clr_cnt_r;
      upper_wdata = '0;
      mid_wdata   = '0;
    end else begin
      ram_we      = adv && s1_valid_r;
      ram_waddr   = s1_col_r;
      upper_wdata = mid1;
      mid_wdata   = s1_pix_r;
    end
  end

  sete_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (upper_wdata),
    .rd_en   (in_acc),
    .rd_addr (c0),
    .rd_data (rd_upper)
  );

  sete_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (mid_wdata),
    .rd_en   (in_acc),
    .rd_addr (c0),
    .rd_data (rd_mid)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clear_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_tdata;
      s1_col_r    <= c0;
      s1_row_r    <= r0 - ROW_W'(1);
      s1_int_r    <= interior0;
      s1_eof_r    <= eof0;
      s1_fwd_r    <= s1_valid_r && (s1_col_r == c0);
      fwd_upper_r <= mid1;
      fwd_mid_r   <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: 3x3 window, row major, top row first. Shifts left by one column.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] win_r [9];
  logic             s2_valid_r, s2_int_r, s2_eof_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= top1;
      win_r[3] <= win_r[4]; win_r[4] <= win_r[5]; win_r[5] <= mid1;
      win_r[6] <= win_r[7]; win_r[7] <= win_r[8]; win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_int_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r <= s1_row_r;
      s2_col_r <= s1_col_r - COL_W'(1);
      s2_eof_r <= s1_eof_r;
    end
  end

  // gradients: gx = right col - left col, gy = top row - bottom row, weights 1,2,1
  logic [9:0]         gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [10:0] gx, gy;

  always_comb begin
    gx_pos = {2'b00, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b00, win_r[8]};
    gx_neg = {2'b00, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b00, win_r[6]};
    gy_pos = {2'b00, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b00, win_r[2]};
    gy_neg = {2'b00, win_r[6]} + {1'b0, win_r[7], 1'b0} + {2'b00, win_r[8]};
    gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
  end

  // ---------------------------------------------------------------------------
  // Stage 3: |gx| + |gy| and threshold compare.
  // ---------------------------------------------------------------------------
  logic               s3_valid_r, s3_eof_r;
  logic [ROW_W-1:0]   s3_row_r;
  logic [COL_W-1:0]   s3_col_r;
  logic signed [10:0] s3_gx_r, s3_gy_r;
  logic [9:0]         abs_gx, abs_gy;
  logic [10:0]        mag;
  logic               produce;
  logic [PIX_W-1:0]   edge_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_gx_r  <= gx;
      s3_gy_r  <= gy;
      s3_row_r <= s2_row_r;
      s3_col_r <= s2_col_r;
      s3_eof_r <= s2_eof_r;
    end
  end

  always_comb begin
    abs_gx   = s3_gx_r[10] ? 10'(-s3_gx_r) : s3_gx_r[9:0];
    abs_gy   = s3_gy_r[10] ? 10'(-s3_gy_r) : s3_gy_r[9:0];
    mag      = {1'b0, abs_gx} + {1'b0, abs_gy};
    edge_val = ({1'b0, mag} > threshold_r) ? EDGE_ON : '0;
    produce  = adv && s3_valid_r;
  end

  // ---------------------------------------------------------------------------
  // Output register with skid.
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_edge_r, skid_edge_r;
  logic [ROW_W-1:0]  out_row_r, skid_row_r;
  logic [COL_W-1:0]  out_col_r, skid_col_r;
  logic              out_eof_r, skid_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_tready) begin
      if (produce) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_tready) begin
      if (produce) begin
        skid_edge_r <= edge_val;
        skid_row_r  <= s3_row_r;
        skid_col_r  <= s3_col_r;
        skid_eof_r  <= s3_eof_r;
      end
    end else if (skid_valid_r) begin
      out_edge_r <= skid_edge_r;
      out_row_r  <= skid_row_r;
      out_col_r  <= skid_col_r;
      out_eof_r  <= skid_eof_r;
    end else if (produce) begin
      out_edge_r <= edge_val;
      out_row_r  <= s3_row_r;
      out_col_r  <= s3_col_r;
      out_eof_r  <= s3_eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_col_r, out_row_r, out_edge_r};
  assign out_tlast  = out_eof_r;

endmodule
